// ===== rtl/trbf_pkg.sv =====
// trbf_pkg: shared types, sizes and codes for the two-reader broadcast FIFO.
// No dependencies; imported by the top level, the checker and the bench (not trbf_ram).
package trbf_pkg;

	localparam int DEPTH         = 16;
	localparam int PAYLOAD_WIDTH = 64;
	localparam int IDX_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W         = $clog2(DEPTH + 1);

	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [PAYLOAD_WIDTH-1:0] data_t;
	typedef logic [1:0]               mark_t;
	typedef logic [1:0]               status_t;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_NO_DATA = 2'd1;
	localparam status_t ST_FULL    = 2'd2;

	localparam mark_t MARK_NONE = 2'd0;
	localparam mark_t MARK_R0   = 2'd1;
	localparam mark_t MARK_R1   = 2'd2;

	function automatic idx_t next_slot(input idx_t i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : idx_t'(i + IDX_W'(1));
	endfunction

endpackage

// ===== rtl/trbf_ram.sv =====
// trbf_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies; holds the records and the read marks.
module trbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/two_reader_broadcast_fifo_unit.sv =====
// two_reader_broadcast_fifo_unit: top level of the two-reader broadcast FIFO.
// Depends on trbf_pkg and trbf_ram (record store and read-mark store).
//
// Usage:
// Input channel (in_valid/in_stall) carries one word: op, payload, reader.
// op = push appends payload with a cleared read mark, or answers full.
// op = read by reader 0 or 1 returns the oldest record this reader has not
// seen; a record is freed once both readers have read it.
// Output channel (out_valid/out_stall) carries one word per input word:
// status (ok, no data, full) and read_data (zero unless a read succeeds).
// Flow: a push or an empty read goes straight to S_FIN; any other read first
// checks the head's mark (S_HEAD) and, if this reader has read the head, walks
// the later entries one per cycle (S_SCAN) until an unread one or the tail.
// Items are handled one at a time, paced by the registered mark-store read.
// A new word is accepted as soon as the previous result sits in the output
// register, even while out_stall holds it.
// Reset: queue empty, output empty; the stores need no clearing pass.
// While out_stall is high the output word holds and at most one finished
// result waits internally.
module two_reader_broadcast_fifo_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  op,
	input  logic [63:0]           payload,
	input  logic                  reader,
	output logic                  out_valid,
	input  logic                  out_stall,
	output trbf_pkg::status_t     status,
	output logic [63:0]           read_data
);
	import trbf_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_HEAD = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0] state_q;
	idx_t       head_q, tail_q, scan_idx_q;
	cnt_t       count_q, scan_k_q;
	mark_t      mine_q;
	status_t    res_status_q, status_q;
	data_t      res_data_q, data_q;
	logic       out_valid_q;

	logic  accept;
	logic  load_out;
	logic  rec_we, mark_we;
	idx_t  mark_waddr, raddr;
	mark_t mark_wdata, mark_rdata;
	data_t rec_rdata;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign load_out = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	always_comb begin
		rec_we     = 1'b0;
		mark_we    = 1'b0;
		mark_waddr = head_q;
		mark_wdata = MARK_NONE;
		raddr      = head_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && op == OP_PUSH && count_q != CNT_W'(DEPTH)) begin
					rec_we     = 1'b1;
					mark_we    = 1'b1;
					mark_waddr = tail_q;
				end
			end
			S_HEAD: begin
				raddr = next_slot(head_q);
				if (mark_rdata == MARK_NONE) begin
					mark_we    = 1'b1;
					mark_wdata = mine_q;
				end else if (mark_rdata != mine_q) begin
					mark_we    = 1'b1;
				end
			end
			S_SCAN: begin
				raddr      = next_slot(scan_idx_q);
				mark_waddr = scan_idx_q;
				if (mark_rdata == MARK_NONE) begin
					mark_we    = 1'b1;
					mark_wdata = mine_q;
				end
			end
			default: begin
			end
		endcase
	end

	trbf_ram #(.WIDTH(PAYLOAD_WIDTH), .DEPTH(DEPTH)) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (tail_q),
		.wdata (payload[PAYLOAD_WIDTH-1:0]),
		.raddr (raddr),
		.rdata (rec_rdata)
	);

	trbf_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_mark_ram (
		.clk   (clk),
		.we    (mark_we),
		.waddr (mark_waddr),
		.wdata (mark_wdata),
		.raddr (raddr),
		.rdata (mark_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			scan_idx_q  <= '0;
			scan_k_q    <= '0;
			mine_q      <= MARK_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						mine_q <= reader ? MARK_R1 : MARK_R0;
						if (op == OP_PUSH) begin
							state_q <= S_FIN;
							if (count_q != CNT_W'(DEPTH)) begin
								tail_q  <= next_slot(tail_q);
								count_q <= cnt_t'(count_q + 1'b1);
							end
						end else if (count_q == '0) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_HEAD;
						end
					end
				end
				S_HEAD: begin
					if (mark_rdata == MARK_NONE) begin
						state_q <= S_FIN;
					end else if (mark_rdata != mine_q) begin
						head_q  <= next_slot(head_q);
						count_q <= cnt_t'(count_q - 1'b1);
						state_q <= S_FIN;
					end else if (count_q == CNT_W'(1)) begin
						state_q <= S_FIN;
					end else begin
						scan_idx_q <= next_slot(head_q);
						scan_k_q   <= CNT_W'(1);
						state_q    <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (mark_rdata == MARK_NONE ||
					    cnt_t'(scan_k_q + 1'b1) == count_q) begin
						state_q <= S_FIN;
					end else begin
						scan_idx_q <= next_slot(scan_idx_q);
						scan_k_q   <= cnt_t'(scan_k_q + 1'b1);
					end
				end
				S_FIN: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				res_data_q <= '0;
				if (op == OP_PUSH) begin
					res_status_q <= (count_q == CNT_W'(DEPTH)) ? ST_FULL : ST_OK;
				end else begin
					res_status_q <= ST_NO_DATA;
				end
			end
			S_HEAD: begin
				if (mark_rdata != mine_q) begin
					res_status_q <= ST_OK;
					res_data_q   <= rec_rdata;
				end
			end
			S_SCAN: begin
				if (mark_rdata == MARK_NONE) begin
					res_status_q <= ST_OK;
					res_data_q   <= rec_rdata;
				end
			end
			S_FIN: begin
				if (load_out) begin
					status_q <= res_status_q;
					data_q   <= res_data_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign read_data = 64'(data_q);

endmodule

// ===== rtl/trbf_checker.sv =====
// trbf_checker: port-level checks for two_reader_broadcast_fifo_unit, with bind.
// Depends on trbf_pkg for status codes.
module trbf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input trbf_pkg::status_t status,
	input logic [63:0]       read_data
);
	import trbf_pkg::*;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_NO_DATA || status == ST_FULL))
		else $error("illegal status code");

	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (read_data == 64'd0))
		else $error("nonzero read_data on failed word");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(read_data)))
		else $error("stalled output word changed");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second word accepted while busy");

endmodule

bind two_reader_broadcast_fifo_unit trbf_checker u_trbf_checker (.*);

// ===== verif/two_reader_broadcast_fifo_unit_tb.sv =====
// Self-checking bench for two_reader_broadcast_fifo_unit: directed and random words,
// with a queue predictor that tracks read marks and output checks on every result.
// Depends on trbf_pkg and the RTL of the block.
`timescale 1ns / 100ps

module two_reader_broadcast_fifo_unit_tb;
	import trbf_pkg::*;

	typedef struct {
		status_t     st;
		logic [63:0] data;
	} fifo_reply_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        op = OP_PUSH;
	logic [63:0] payload = '0;
	logic        reader = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	status_t     status;
	logic [63:0] read_data;

	// predictor copy of the queue
	logic [63:0] q_store [DEPTH];
	mark_t       q_mark [DEPTH];
	int          q_head = 0;
	int          q_tail = 0;
	int          q_count = 0;

	fifo_reply_t pending_replies [$];

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int hold_req = 0;
	int hold_left = 0;
	int err_count = 0;
	int words_sent = 0;
	int results_checked = 0;
	int n_ok = 0;
	int n_no_data = 0;
	int n_full = 0;

	two_reader_broadcast_fifo_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.payload   (payload),
		.reader    (reader),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.read_data (read_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int advance_idx(input int i);
		return (i == DEPTH - 1) ? 0 : i + 1;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic fifo_reply_t compute_fifo_reply(input logic o, input logic [63:0] p,
			input logic r);
		fifo_reply_t rep;
		mark_t       mine;
		int          idx;
		rep.st = ST_NO_DATA;
		rep.data = '0;
		mine = r ? MARK_R1 : MARK_R0;
		if (o == OP_PUSH) begin
			if (q_count >= DEPTH) begin
				rep.st = ST_FULL;
			end else begin
				q_store[q_tail] = 64'(data_t'(p));
				q_mark[q_tail] = MARK_NONE;
				q_tail = advance_idx(q_tail);
				q_count++;
				rep.st = ST_OK;
			end
		end else if (q_count != 0) begin
			if (q_mark[q_head] == MARK_NONE) begin
				rep.data = q_store[q_head];
				q_mark[q_head] = mine;
				rep.st = ST_OK;
			end else if (q_mark[q_head] != mine) begin
				rep.data = q_store[q_head];
				q_mark[q_head] = MARK_NONE;
				q_head = advance_idx(q_head);
				q_count--;
				rep.st = ST_OK;
			end else begin
				idx = q_head;
				for (int k = 0; k < q_count; k++) begin
					if (q_mark[idx] == MARK_NONE) begin
						rep.data = q_store[idx];
						q_mark[idx] = mine;
						rep.st = ST_OK;
						break;
					end
					idx = advance_idx(idx);
				end
			end
		end
		return rep;
	endfunction

	task automatic send_word(input logic o, input logic [63:0] p, input logic r);
		fifo_reply_t rep;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		payload <= p;
		reader <= r;
		do @(posedge clk); while (in_stall);
		rep = compute_fifo_reply(o, p, r);
		pending_replies.push_back(rep);
		words_sent++;
		case (rep.st)
			ST_OK:      n_ok++;
			ST_NO_DATA: n_no_data++;
			default:    n_full++;
		endcase
	endtask

	// sender goes quiet until every outstanding result is back
	task automatic settle_results();
		in_valid <= 1'b0;
		for (int c = 0; c < 50000 && pending_replies.size() != 0; c++)
			@(posedge clk);
		repeat (DEPTH + 4) @(posedge clk);
	endtask

	// receiver: random stalls, plus long holds on request
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		fifo_reply_t want;
		if (out_valid && !out_stall) begin
			if (pending_replies.size() == 0) begin
				$error("unexpected result: status=%0d read_data=%h", status, read_data);
				err_count++;
			end else begin
				want = pending_replies.pop_front();
				results_checked++;
				if (status !== want.st) begin
					$error("status: expected %0d, actual %0d", want.st, status);
					err_count++;
				end
				if (read_data !== want.data) begin
					$error("read_data: expected %h, actual %h", want.data, read_data);
					err_count++;
				end
			end
		end
	end

	task automatic test_empty_reads();
		send_word(OP_READ, rand64(), 1'b0);
		send_word(OP_READ, rand64(), 1'b1);
	endtask

	task automatic test_payload_extremes();
		send_word(OP_PUSH, 64'h0, 1'b1);
		send_word(OP_PUSH, '1, 1'b0);
		send_word(OP_PUSH, 64'h5555_5555_5555_5555, 1'b1);
		send_word(OP_PUSH, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
	endtask

	// reader 0 walks all four, runs dry, reader 1 frees them; then the mirror case on two new records
	task automatic test_read_marks();
		repeat (5) send_word(OP_READ, rand64(), 1'b0);
		repeat (5) send_word(OP_READ, rand64(), 1'b1);
		send_word(OP_PUSH, rand64(), 1'b0);
		send_word(OP_PUSH, rand64(), 1'b1);
		send_word(OP_READ, rand64(), 1'b1);
		send_word(OP_READ, rand64(), 1'b1);
		send_word(OP_READ, rand64(), 1'b0);
		send_word(OP_READ, rand64(), 1'b0);
	endtask

	task automatic test_fill_to_full();
		while (q_count < DEPTH)
			send_word(OP_PUSH, rand64(), 1'($urandom_range(1)));
		send_word(OP_PUSH, rand64(), 1'b0);
		send_word(OP_PUSH, rand64(), 1'b1);
	endtask

	task automatic test_random(input int n_words, input int src_pct, input int sink_pct);
		int push_pct;
		int r1_pct;
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		push_pct = 50;
		r1_pct = 50;
		for (int i = 0; i < n_words; i++) begin
			if (i % 32 == 0) begin
				case ($urandom_range(2))
					0: push_pct = 15;
					1: push_pct = 50;
					default: push_pct = 85;
				endcase
				case ($urandom_range(2))
					0: r1_pct = 10;
					1: r1_pct = 50;
					default: r1_pct = 90;
				endcase
			end
			send_word(($urandom_range(99) < push_pct) ? OP_PUSH : OP_READ, rand64(),
				$urandom_range(99) < r1_pct);
		end
	endtask

	task automatic test_output_backpressure();
		hold_req = 120;
		for (int i = 0; i < 30; i++)
			send_word(($urandom_range(2) != 0) ? OP_PUSH : OP_READ, rand64(),
				1'($urandom_range(1)));
	endtask

	task automatic test_sender_pause();
		repeat (8) send_word(1'($urandom_range(1)), rand64(), 1'($urandom_range(1)));
		settle_results();
		repeat (8) send_word(1'($urandom_range(1)), rand64(), 1'($urandom_range(1)));
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_idle_pct = 18;
		sink_stall_pct = 46;
		test_empty_reads();
		test_payload_extremes();
		test_read_marks();
		test_fill_to_full();
		test_random(330, 18, 46);
		test_output_backpressure();
		test_sender_pause();
		test_random(330, 46, 18);
		settle_results();
		test_random(330, 0, 0);
		settle_results();
		if (pending_replies.size() != 0) begin
			$error("%0d results never arrived", pending_replies.size());
			err_count++;
		end
		$display("Sent %0d words, checked %0d results: %0d ok, %0d no data, %0d full.",
			words_sent, results_checked, n_ok, n_no_data, n_full);
		$display("Idle mixes sender-heavy, receiver-heavy and none;");
		$display("long output hold and drain pause.");
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5_000_000;
		$error("timeout");
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/trbf_pkg.sv
rtl/trbf_ram.sv
rtl/two_reader_broadcast_fifo_unit.sv
rtl/trbf_checker.sv
verif/two_reader_broadcast_fifo_unit_tb.sv
